// ----- rtl/core/bts_pkg.sv -----
// Shared types, codes and helpers for the operand type stack tracker.
package bts_pkg;

	typedef enum logic [3:0] {
		FN_PUSH    = 4'd0,
		FN_TPOP    = 4'd1,
		FN_POP     = 4'd2,
		FN_POP2    = 4'd3,
		FN_DUP     = 4'd4,
		FN_DUP_X1  = 4'd5,
		FN_DUP_X2  = 4'd6,
		FN_DUP2    = 4'd7,
		FN_DUP2_X1 = 4'd8,
		FN_DUP2_X2 = 4'd9,
		FN_SWAP    = 4'd10,
		FN_CLEAR   = 4'd11
	} func_t;

	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_FAIL    = 3'd1;
	localparam logic [2:0] ST_OVER    = 3'd2;
	localparam logic [2:0] ST_BADTYPE = 3'd3;
	localparam logic [2:0] ST_NOPUSH  = 3'd4;

	localparam logic [3:0] TY_DEFAULT     = 4'd0;
	localparam logic [3:0] TY_INT         = 4'd1;
	localparam logic [3:0] TY_LONG        = 4'd2;
	localparam logic [3:0] TY_FLOAT       = 4'd3;
	localparam logic [3:0] TY_DOUBLE      = 4'd4;
	localparam logic [3:0] TY_BYTE        = 4'd5;
	localparam logic [3:0] TY_CHAR        = 4'd6;
	localparam logic [3:0] TY_SHORT       = 4'd7;
	localparam logic [3:0] TY_REF         = 4'd8;
	localparam logic [3:0] TY_ADDR        = 4'd9;
	localparam logic [3:0] TY_LONG_FILL   = 4'd10;
	localparam logic [3:0] TY_DOUBLE_FILL = 4'd11;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LAST,
		S_EVAL,
		S_WRITE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic       load;
		logic       rd;
		logic [1:0] rd_k;
		logic       eval;
		logic       wr;
		logic [2:0] wr_i;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0] n_put;
	} dp_stat_t;

	function automatic logic is_cat1(input logic [3:0] t);
		return (t == TY_INT) || (t == TY_FLOAT) || (t >= TY_BYTE && t <= TY_ADDR);
	endfunction

	function automatic logic is_cat2(input logic [3:0] t);
		return (t == TY_LONG) || (t == TY_DOUBLE);
	endfunction

	function automatic logic is_filler(input logic [3:0] t);
		return (t == TY_LONG_FILL) || (t == TY_DOUBLE_FILL);
	endfunction

endpackage

// ----- rtl/core/bts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bts_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/bts_dp.sv -----
// Datapath: slot memory, top-four slot capture, operation evaluation and result registers.
module bts_dp import bts_pkg::*; #(
	parameter int MAX_SLOTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_stat_t   stat,
	input  logic [3:0] in_func,
	input  logic [3:0] in_type,
	output logic       ok,
	output logic [2:0] status,
	output logic [6:0] depth,
	output logic [3:0] top_type
);

	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int AW = $clog2(MAX_SLOTS);

	logic [3:0]    func_q, type_q;
	logic [CW-1:0] count_q;
	logic [3:0]    t_q [4];
	logic          cap_q;
	logic [1:0]    cap_k_q;
	logic [2:0]    st_q;
	logic [3:0]    top_q;
	logic [CW-1:0] base_q;
	logic [2:0]    n_q;
	logic [3:0]    put_q [6];

	logic [3:0]    rdata;
	logic [AW-1:0] raddr, waddr;

	logic [3:0]    ty, want, top_c;
	logic [2:0]    st_c, drop_c, n_c;
	logic          clr_c;
	logic [3:0]    put_c [6];
	logic [CW-1:0] base_c, count_c;
	logic [CW:0]   sum_c;

	assign raddr = AW'(count_q - CW'({1'b0, cmd.rd_k}) - CW'(1));
	assign waddr = AW'(base_q + CW'(cmd.wr_i));

	bts_ram #(.WIDTH(4), .DEPTH(MAX_SLOTS)) u_slots (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (waddr),
		.wdata (put_q[cmd.wr_i]),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		ty     = (type_q >= TY_BYTE && type_q <= TY_SHORT) ? TY_INT : type_q;
		want   = (ty == TY_LONG) ? TY_LONG_FILL : TY_DOUBLE_FILL;
		st_c   = ST_DONE;
		drop_c = 3'd0;
		n_c    = 3'd0;
		clr_c  = 1'b0;
		top_c  = t_q[0];
		for (int i = 0; i < 6; i++) begin
			put_c[i] = TY_DEFAULT;
		end
		case (func_q)
			FN_PUSH: begin
				if (type_q == TY_DEFAULT) begin
					st_c = ST_NOPUSH;
				end else if (type_q > TY_ADDR) begin
					st_c = ST_BADTYPE;
				end else begin
					put_c[0] = ty;
					if (ty == TY_LONG) begin
						put_c[1] = TY_LONG_FILL;
						n_c      = 3'd2;
					end else if (ty == TY_DOUBLE) begin
						put_c[1] = TY_DOUBLE_FILL;
						n_c      = 3'd2;
					end else begin
						n_c = 3'd1;
					end
				end
			end
			FN_TPOP: begin
				if (type_q > TY_ADDR) begin
					st_c = ST_BADTYPE;
				end else if (count_q == '0) begin
					st_c = ST_FAIL;
				end else if (ty == TY_DEFAULT) begin
					st_c = ST_DONE;
				end else if (is_cat2(ty)) begin
					if (count_q >= CW'(2) && t_q[0] == want) drop_c = 3'd2;
					else st_c = ST_FAIL;
				end else if (t_q[0] == ty) begin
					drop_c = 3'd1;
				end else begin
					st_c = ST_FAIL;
				end
			end
			FN_POP: begin
				if (count_q >= CW'(1) && is_cat1(t_q[0])) drop_c = 3'd1;
				else st_c = ST_FAIL;
			end
			FN_POP2: begin
				if (count_q >= CW'(2) && is_filler(t_q[0])) drop_c = 3'd2;
				else st_c = ST_FAIL;
			end
			FN_DUP: begin
				if (count_q >= CW'(1) && is_cat1(t_q[0])) begin
					put_c[0] = t_q[0];
					n_c      = 3'd1;
				end else begin
					st_c = ST_FAIL;
				end
			end
			FN_DUP_X1: begin
				if (count_q >= CW'(2) && is_cat1(t_q[0]) && is_cat1(t_q[1])) begin
					put_c[0] = t_q[0];
					put_c[1] = t_q[1];
					put_c[2] = t_q[0];
					drop_c   = 3'd2;
					n_c      = 3'd3;
				end else begin
					st_c = ST_FAIL;
				end
			end
			FN_DUP_X2: begin
				if (count_q >= CW'(3) && is_cat1(t_q[0])) begin
					put_c[0] = t_q[0];
					put_c[1] = t_q[2];
					put_c[2] = t_q[1];
					put_c[3] = t_q[0];
					drop_c   = 3'd3;
					n_c      = 3'd4;
				end else begin
					st_c = ST_FAIL;
				end
			end
			FN_DUP2: begin
				if (count_q >= CW'(2) && ((is_cat1(t_q[0]) && is_cat1(t_q[1])) ||
						(is_filler(t_q[0]) && is_cat2(t_q[1])))) begin
					put_c[0] = t_q[1];
					put_c[1] = t_q[0];
					put_c[2] = t_q[1];
					put_c[3] = t_q[0];
					drop_c   = 3'd2;
					n_c      = 3'd4;
				end else begin
					st_c = ST_FAIL;
				end
			end
			FN_DUP2_X1: begin
				if (count_q >= CW'(3) && is_cat1(t_q[2])) begin
					put_c[0] = t_q[1];
					put_c[1] = t_q[0];
					put_c[2] = t_q[2];
					put_c[3] = t_q[1];
					put_c[4] = t_q[0];
					drop_c   = 3'd3;
					n_c      = 3'd5;
				end else begin
					st_c = ST_FAIL;
				end
			end
			FN_DUP2_X2: begin
				if (count_q >= CW'(4)) begin
					put_c[0] = t_q[1];
					put_c[1] = t_q[0];
					put_c[2] = t_q[3];
					put_c[3] = t_q[2];
					put_c[4] = t_q[1];
					put_c[5] = t_q[0];
					drop_c   = 3'd4;
					n_c      = 3'd6;
				end else begin
					st_c = ST_FAIL;
				end
			end
			FN_SWAP: begin
				if (count_q >= CW'(2) && is_cat1(t_q[0]) && is_cat1(t_q[1])) begin
					put_c[0] = t_q[0];
					put_c[1] = t_q[1];
					drop_c   = 3'd2;
					n_c      = 3'd2;
				end else begin
					st_c = ST_FAIL;
				end
			end
			FN_CLEAR: clr_c = 1'b1;
			default:  st_c = ST_FAIL;
		endcase

		base_c = count_q - CW'(drop_c);
		sum_c  = {1'b0, base_c} + (CW+1)'(n_c);
		if (st_c == ST_DONE && !clr_c && sum_c > (CW+1)'(MAX_SLOTS)) begin
			st_c = ST_OVER;
		end

		count_c = count_q;
		if (st_c == ST_DONE) begin
			count_c = clr_c ? '0 : sum_c[CW-1:0];
			if (clr_c) begin
				top_c = TY_DEFAULT;
			end else if (n_c != 3'd0) begin
				for (int i = 0; i < 6; i++) begin
					if (n_c == 3'(i + 1)) top_c = put_c[i];
				end
			end else begin
				case (drop_c)
					3'd0:    top_c = t_q[0];
					3'd1:    top_c = t_q[1];
					default: top_c = t_q[2];
				endcase
			end
		end else begin
			n_c = 3'd0;
		end
	end

	// empty slots below the stack read as the default type
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= 1'b0;
			cap_k_q <= '0;
			n_q     <= '0;
		end else begin
			cap_q   <= cmd.rd;
			cap_k_q <= cmd.rd_k;
			if (cmd.eval) begin
				count_q <= count_c;
				n_q     <= n_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			type_q <= in_type;
		end
		if (cap_q) begin
			t_q[cap_k_q] <= (count_q > CW'(cap_k_q)) ? rdata : TY_DEFAULT;
		end
		if (cmd.eval) begin
			st_q   <= st_c;
			top_q  <= top_c;
			base_q <= base_c;
			put_q  <= put_c;
		end
	end

	assign stat.n_put = n_q;
	assign ok         = (st_q == ST_DONE);
	assign status     = st_q;
	assign depth      = 7'(count_q);
	assign top_type   = top_q;

endmodule

// ----- rtl/core/bts_ctrl.sv -----
// Controller: sequences accept, slot reads, evaluation, slot writes and the result word.
module bts_ctrl import bts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t     state_q, state_d;
	logic [1:0] k_q, k_d;
	logic [2:0] wi_q, wi_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			wi_q    <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			wi_q    <= wi_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		wi_d      = wi_q;
		cmd       = '0;
		cmd.rd_k  = k_q;
		cmd.wr_i  = wi_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					k_d      = '0;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd = 1'b1;
				k_d    = k_q + 2'd1;
				if (k_q == 2'd3) state_d = S_LAST;
			end
			S_LAST: state_d = S_EVAL;
			S_EVAL: begin
				cmd.eval = 1'b1;
				wi_d     = '0;
				state_d  = S_WRITE;
			end
			S_WRITE: begin
				if (wi_q == stat.n_put) begin
					state_d = S_RESP;
				end else begin
					cmd.wr = 1'b1;
					wi_d   = wi_q + 3'd1;
				end
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/bytecode_type_stack_tracker_unit.sv -----
// Top level of the operand type stack tracker: controller, datapath and port packing.
//
//  channel  | dir | word layout (low bit first)
//  s_axis   | in  | func[3:0], item_type[7:4]
//  m_axis   | out | ok[0], status[3:1], depth[10:4], top_type[14:11], zero[15]
//
// An operation runs: accept, four slot reads through the single RAM read
// port, capture, evaluate, one write per slot put (0 to 6), a final write-state
// check, then the result word. A new word is taken only after the result is
// taken. Reset empties the stack; no clearing pass. m_tready low holds the result.
module bytecode_type_stack_tracker_unit import bts_pkg::*; #(
	parameter int MAX_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // func, item_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // ok, status, depth, top_type, pad
);

	ctrl_cmd_t  cmd;
	dp_stat_t   stat;
	logic       ok;
	logic [2:0] status;
	logic [6:0] depth;
	logic [3:0] top_type;

	bts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bts_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_func  (s_tdata[3:0]),
		.in_type  (s_tdata[7:4]),
		.ok       (ok),
		.status   (status),
		.depth    (depth),
		.top_type (top_type)
	);

	assign m_tdata = {1'b0, top_type, depth, status, ok};

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result is pending");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
		else $error("controller did not go busy after accept");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == ST_DONE)))
		else $error("ok flag disagrees with status");
`endif

endmodule
